// ===== design/circle_canvas_rasterizer_assert.svh =====
// Assertion macros used by the checker file of the circle canvas rasterizer.
`ifndef CIRCLE_CANVAS_RASTERIZER_ASSERT_SVH
`define CIRCLE_CANVAS_RASTERIZER_ASSERT_SVH

// Clocked assertion that is switched off while reset is high.
`define CCR_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that is also checked through reset.
`define CCR_ASSERT_NR(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/ccr_pkg.sv =====
// Shared types, codes and constants of the circle canvas rasterizer.
package ccr_pkg;

   // Fixed field widths.
   localparam int COORD_W     = 24;
   localparam int BYTE_W      = 8;
   localparam int MODE_W      = 2;
   localparam int STATUS_W    = 2;
   localparam int CFG_W       = 9;
   localparam int CSR_INDEX_W = 2;
   localparam int SQ_SEL_W    = 2;

   // Request modes.
   localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd0;
   localparam logic [MODE_W-1:0] MODE_DRAW  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;
   localparam logic [MODE_W-1:0] MODE_NOP   = 2'd3;

   // Response status codes.
   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_SHAPE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

   // Circle kind bytes.
   localparam logic [BYTE_W-1:0] KIND_OUTLINE = 8'h63;
   localparam logic [BYTE_W-1:0] KIND_FILLED  = 8'h43;

   // Configuration register indexes and reset values.
   localparam logic [CSR_INDEX_W-1:0] CSR_WIDTH      = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HEIGHT     = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BACKGROUND = 2'd2;
   localparam logic [CFG_W-1:0]       WIDTH_RESET      = 9'd1;
   localparam logic [CFG_W-1:0]       HEIGHT_RESET     = 9'd1;
   localparam logic [BYTE_W-1:0]      BACKGROUND_RESET = 8'd32;

   // Operand selects of the shared squaring multiplier.
   localparam logic [SQ_SEL_W-1:0] SQ_CX = 2'd0;
   localparam logic [SQ_SEL_W-1:0] SQ_CY = 2'd1;
   localparam logic [SQ_SEL_W-1:0] SQ_R  = 2'd2;
   localparam logic [SQ_SEL_W-1:0] SQ_RI = 2'd3;

   // Request data, last field in the lowest bits.
   typedef struct packed {
      logic [BYTE_W-1:0]         read_col;
      logic [BYTE_W-1:0]         read_row;
      logic [BYTE_W-1:0]         paint_byte;
      logic signed [COORD_W-1:0] radius;
      logic signed [COORD_W-1:0] center_y;
      logic signed [COORD_W-1:0] center_x;
   } req_data_type;

   // Request side-band: mode and circle kind.
   typedef struct packed {
      logic [BYTE_W-1:0] shape_kind;
      logic [MODE_W-1:0] mode;
   } req_user_type;

   // Response data, padded to whole bytes.
   typedef struct packed {
      logic [6:0]        pad;
      logic              error_seen;
      logic [BYTE_W-1:0] pixel_value;
   } rsp_data_type;

   localparam int REQ_TDATA_W = $bits(req_data_type);
   localparam int REQ_TUSER_W = $bits(req_user_type);
   localparam int RSP_TDATA_W = $bits(rsp_data_type);

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic                capture;
      logic                scan_init;
      logic                scan_step;
      logic                sq_load;
      logic [SQ_SEL_W-1:0] sq_sel;
      logic                flag_set;
      logic                flag_clr;
      logic                load_rsp;
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic              shape_bad;
      logic              scan_done;
   } dp_status_type;

endpackage

// ===== design/ccr_ctrl.sv =====
// Controller state machine of the circle canvas rasterizer.
module ccr_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  ccr_pkg::dp_status_type stat,
   output ccr_pkg::ctrl_cmd_type  cmd
);

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_DISPATCH = 3'd1;
   localparam logic [2:0] S_SQ_CY    = 3'd2;
   localparam logic [2:0] S_SQ_R     = 3'd3;
   localparam logic [2:0] S_SQ_RI    = 3'd4;
   localparam logic [2:0] S_SCAN     = 3'd5;
   localparam logic [2:0] S_DRAIN    = 3'd6;
   localparam logic [2:0] S_RESP     = 3'd7;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            unique case (stat.mode)
               ccr_pkg::MODE_CLEAR: begin
                  cmd.scan_init = 1'b1;
                  cmd.flag_clr  = 1'b1;
                  state_in      = S_SCAN;
               end
               ccr_pkg::MODE_DRAW: begin
                  if (stat.shape_bad) begin
                     cmd.flag_set = 1'b1;
                     state_in     = S_RESP;
                  end else begin
                     cmd.sq_load = 1'b1;
                     cmd.sq_sel  = ccr_pkg::SQ_CX;
                     state_in    = S_SQ_CY;
                  end
               end
               ccr_pkg::MODE_READ: state_in = S_RESP;
               ccr_pkg::MODE_NOP:  state_in = S_RESP;
            endcase
         end
         S_SQ_CY: begin
            cmd.sq_load = 1'b1;
            cmd.sq_sel  = ccr_pkg::SQ_CY;
            state_in    = S_SQ_R;
         end
         S_SQ_R: begin
            cmd.sq_load = 1'b1;
            cmd.sq_sel  = ccr_pkg::SQ_R;
            state_in    = S_SQ_RI;
         end
         S_SQ_RI: begin
            // Center squares are in place, so the scan can start here too.
            cmd.sq_load   = 1'b1;
            cmd.sq_sel    = ccr_pkg::SQ_RI;
            cmd.scan_init = 1'b1;
            state_in      = S_SCAN;
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (stat.scan_done) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in = S_RESP;
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
      endcase
   end

   // Response valid flag of the output register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      priority if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

endmodule

// ===== design/ccr_datapath.sv =====
// Datapath of the circle canvas rasterizer: request latch, squares, scan and canvas.
module ccr_datapath #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256,
   parameter int FRAC_BITS  = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  ccr_pkg::ctrl_cmd_type              cmd,
   output ccr_pkg::dp_status_type             stat,
   input  ccr_pkg::req_data_type              req_data,
   input  ccr_pkg::req_user_type              req_user,
   input  logic [ccr_pkg::CFG_W-1:0]          cfg_width,
   input  logic [ccr_pkg::CFG_W-1:0]          cfg_height,
   input  logic [ccr_pkg::BYTE_W-1:0]         cfg_background,
   output ccr_pkg::rsp_data_type              rsp_data,
   output logic [ccr_pkg::STATUS_W-1:0]       rsp_status
);

   localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int ROW_W  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int ADDR_W = ROW_W + COL_W;
   localparam int DEPTH  = 1 << ADDR_W;
   localparam int DIM_WA = $clog2(MAX_WIDTH + 1);
   localparam int DIM_HA = $clog2(MAX_HEIGHT + 1);
   localparam int DIM_A  = (DIM_WA > DIM_HA) ? DIM_WA : DIM_HA;
   localparam int DIM_W  = (DIM_A > ccr_pkg::CFG_W) ? DIM_A : ccr_pkg::CFG_W;
   localparam int SPAN_W = ((COL_W > ROW_W) ? COL_W : ROW_W) + FRAC_BITS;
   localparam int MAG_W  = ((SPAN_W > ccr_pkg::COORD_W - 1) ? SPAN_W
                                                            : ccr_pkg::COORD_W - 1) + 1;
   localparam int DIFF_W = MAG_W + 1;
   localparam int SQ_W   = 2 * MAG_W;
   localparam int ACC_W  = SQ_W + 2;
   localparam int D2_W   = SQ_W + 1;
   localparam int RSQ_W  = 2 * ccr_pkg::COORD_W;
   localparam int OP_W   = ccr_pkg::COORD_W + 1;

   localparam logic signed [DIFF_W-1:0] ONE_D  = DIFF_W'(1) << FRAC_BITS;
   localparam logic signed [OP_W-1:0]   ONE_OP = OP_W'(1) << FRAC_BITS;
   localparam logic signed [ACC_W-1:0]  ONE_SQ = ACC_W'(1) << (2 * FRAC_BITS);

   // Request latch.
   logic [ccr_pkg::MODE_W-1:0]         mode_ff;
   logic                               shape_bad_ff;
   logic                               filled_ff;
   logic signed [ccr_pkg::COORD_W-1:0] cx_ff, cy_ff, r_ff;
   logic [ccr_pkg::BYTE_W-1:0]         paint_ff;
   logic [ADDR_W-1:0]                  rd_addr_ff;
   logic                               read_bad_ff;
   logic [COL_W-1:0]                   last_col_ff;
   logic [ROW_W-1:0]                   last_row_ff;

   logic [DIM_W-1:0] used_w, used_h;
   logic             kind_ok;

   // Size in use, clamped to one and to the maximum.
   always_comb begin
      priority if (cfg_width == '0) begin
         used_w = DIM_W'(1);
      end else if (DIM_W'(cfg_width) > DIM_W'(MAX_WIDTH)) begin
         used_w = DIM_W'(MAX_WIDTH);
      end else begin
         used_w = DIM_W'(cfg_width);
      end
      priority if (cfg_height == '0) begin
         used_h = DIM_W'(1);
      end else if (DIM_W'(cfg_height) > DIM_W'(MAX_HEIGHT)) begin
         used_h = DIM_W'(MAX_HEIGHT);
      end else begin
         used_h = DIM_W'(cfg_height);
      end
   end

   assign kind_ok = (req_user.shape_kind == ccr_pkg::KIND_OUTLINE) ||
                    (req_user.shape_kind == ccr_pkg::KIND_FILLED);

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff      <= req_user.mode;
         shape_bad_ff <= req_data.radius[ccr_pkg::COORD_W-1] || (req_data.radius == '0) ||
                         !kind_ok;
         filled_ff    <= (req_user.shape_kind == ccr_pkg::KIND_FILLED);
         cx_ff        <= req_data.center_x;
         cy_ff        <= req_data.center_y;
         r_ff         <= req_data.radius;
         paint_ff     <= req_data.paint_byte;
         rd_addr_ff   <= {ROW_W'(req_data.read_row), COL_W'(req_data.read_col)};
         read_bad_ff  <= (DIM_W'(req_data.read_row) >= used_h) ||
                         (DIM_W'(req_data.read_col) >= used_w);
         last_col_ff  <= COL_W'(used_w - DIM_W'(1));
         last_row_ff  <= ROW_W'(used_h - DIM_W'(1));
      end
   end

   // Shared squaring multiplier, one operand per cycle.
   logic signed [OP_W-1:0]         mul_op;
   logic [ccr_pkg::COORD_W-1:0]    mul_mag;
   logic [RSQ_W-1:0]               mul_prod;
   logic [SQ_W-1:0]                cx_sq_ff, cy_sq_ff;
   logic [RSQ_W-1:0]               r2_ff, ri2_ff;

   always_comb begin
      unique case (cmd.sq_sel)
         ccr_pkg::SQ_CX: mul_op = OP_W'(cx_ff);
         ccr_pkg::SQ_CY: mul_op = OP_W'(cy_ff);
         ccr_pkg::SQ_R:  mul_op = OP_W'(r_ff);
         ccr_pkg::SQ_RI: mul_op = OP_W'(r_ff) - ONE_OP;
      endcase
      mul_mag  = mul_op[OP_W-1] ? ccr_pkg::COORD_W'(-mul_op) : ccr_pkg::COORD_W'(mul_op);
      mul_prod = RSQ_W'(mul_mag) * RSQ_W'(mul_mag);
   end

   always_ff @(posedge clock) begin
      if (cmd.sq_load) begin
         unique case (cmd.sq_sel)
            ccr_pkg::SQ_CX: cx_sq_ff <= SQ_W'(mul_prod);
            ccr_pkg::SQ_CY: cy_sq_ff <= SQ_W'(mul_prod);
            ccr_pkg::SQ_R:  r2_ff    <= mul_prod;
            ccr_pkg::SQ_RI: ri2_ff   <= mul_prod;
         endcase
      end
   end

   // Raster scan with incremental squared offsets: (d + 1)^2 = d^2 + 2d + 1.
   logic [ROW_W-1:0]          row_ff;
   logic [COL_W-1:0]          col_ff;
   logic signed [DIFF_W-1:0]  dx_ff, dy_ff, neg_cx, neg_cy;
   logic [SQ_W-1:0]           dx_sq_ff, dy_sq_ff;
   logic signed [ACC_W-1:0]   dx_acc, dy_acc;
   logic                      last_c, last_r;

   assign neg_cx = -DIFF_W'(cx_ff);
   assign neg_cy = -DIFF_W'(cy_ff);
   assign dx_acc = $signed({2'b00, dx_sq_ff}) + (ACC_W'(dx_ff) <<< (FRAC_BITS + 1)) + ONE_SQ;
   assign dy_acc = $signed({2'b00, dy_sq_ff}) + (ACC_W'(dy_ff) <<< (FRAC_BITS + 1)) + ONE_SQ;
   assign last_c = (col_ff == last_col_ff);
   assign last_r = (row_ff == last_row_ff);

   always_ff @(posedge clock) begin
      priority if (cmd.scan_init) begin
         row_ff   <= '0;
         col_ff   <= '0;
         dx_ff    <= neg_cx;
         dx_sq_ff <= cx_sq_ff;
         dy_ff    <= neg_cy;
         dy_sq_ff <= cy_sq_ff;
      end else if (cmd.scan_step) begin
         if (last_c) begin
            col_ff   <= '0;
            dx_ff    <= neg_cx;
            dx_sq_ff <= cx_sq_ff;
            if (!last_r) begin
               row_ff   <= row_ff + ROW_W'(1);
               dy_ff    <= dy_ff + ONE_D;
               dy_sq_ff <= dy_acc[SQ_W-1:0];
            end
         end else begin
            col_ff   <= col_ff + COL_W'(1);
            dx_ff    <= dx_ff + ONE_D;
            dx_sq_ff <= dx_acc[SQ_W-1:0];
         end
      end
   end

   // Pixel stage: squared distance and address of the pixel being tested.
   logic              p_valid_ff;
   logic [D2_W-1:0]   p_d2_ff;
   logic [ADDR_W-1:0] p_addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
      end else begin
         p_valid_ff <= cmd.scan_step;
      end
   end

   always_ff @(posedge clock) begin
      p_d2_ff   <= D2_W'(dx_sq_ff) + D2_W'(dy_sq_ff);
      p_addr_ff <= {row_ff, col_ff};
   end

   // Coverage test: inside the circle, and for an outline beyond the inner ring.
   logic                       clear_mode, inner_all, in_outer, beyond_inner, mem_we;
   logic [ccr_pkg::BYTE_W-1:0] mem_wdata;

   assign clear_mode   = (mode_ff == ccr_pkg::MODE_CLEAR);
   assign inner_all    = OP_W'(r_ff) < ONE_OP;
   assign in_outer     = p_d2_ff <= D2_W'(r2_ff);
   assign beyond_inner = p_d2_ff > D2_W'(ri2_ff);
   assign mem_we       = p_valid_ff &&
                         (clear_mode || (in_outer && (filled_ff || inner_all || beyond_inner)));
   assign mem_wdata    = clear_mode ? cfg_background : paint_ff;

   // Canvas memory: one write and one registered read per cycle.
   logic [ccr_pkg::BYTE_W-1:0] canvas_mem [DEPTH];
   logic [ccr_pkg::BYTE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         canvas_mem[p_addr_ff] <= mem_wdata;
      end
      rd_data_ff <= canvas_mem[rd_addr_ff];
   end

   // Sticky shape error flag.
   logic err_flag_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         err_flag_ff <= 1'b0;
      end else if (cmd.flag_set) begin
         err_flag_ff <= 1'b1;
      end else if (cmd.flag_clr) begin
         err_flag_ff <= 1'b0;
      end
   end

   // Response register.
   logic [ccr_pkg::STATUS_W-1:0] status_code;
   logic [ccr_pkg::STATUS_W-1:0] rsp_status_ff;
   logic [ccr_pkg::BYTE_W-1:0]   rsp_pixel_ff;
   logic                         rsp_error_ff;

   always_comb begin
      priority if ((mode_ff == ccr_pkg::MODE_DRAW) && shape_bad_ff) begin
         status_code = ccr_pkg::STATUS_SHAPE;
      end else if ((mode_ff == ccr_pkg::MODE_READ) && read_bad_ff) begin
         status_code = ccr_pkg::STATUS_RANGE;
      end else begin
         status_code = ccr_pkg::STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_status_ff <= status_code;
         rsp_pixel_ff  <= ((mode_ff == ccr_pkg::MODE_READ) && !read_bad_ff) ? rd_data_ff : '0;
         rsp_error_ff  <= err_flag_ff;
      end
   end

   assign rsp_status           = rsp_status_ff;
   assign rsp_data.pad         = '0;
   assign rsp_data.error_seen  = rsp_error_ff;
   assign rsp_data.pixel_value = rsp_pixel_ff;

   assign stat.mode      = mode_ff;
   assign stat.shape_bad = shape_bad_ff;
   assign stat.scan_done = last_c && last_r;

endmodule

// ===== design/circle_canvas_rasterizer.sv =====
// Top level of the circle canvas rasterizer: configuration registers, controller, datapath.
// An outline paints only the pixels beyond the inner ring unless the radius is below one unit.
// The scan tests one pixel per cycle and writes through the single canvas write port, so a
// clear or a draw covers the whole W by H canvas; one request is in work at a time.
// Reset is synchronous: control, the sticky error flag and the registers (1, 1, 0x20) are
// cleared; canvas contents are undefined until the first clear.
module circle_canvas_rasterizer #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256,
   parameter int FRAC_BITS  = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   // center_x, center_y, radius, paint_byte, read_row, read_col
   input  logic [ccr_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // mode, shape_kind
   input  logic [ccr_pkg::REQ_TUSER_W-1:0]    req_tuser,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // pixel_value, error_seen, zero pad
   output logic [ccr_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   // status
   output logic [ccr_pkg::STATUS_W-1:0]       rsp_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [ccr_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [ccr_pkg::CFG_W-1:0]          csr_data
);

   ccr_pkg::ctrl_cmd_type  cmd;
   ccr_pkg::dp_status_type stat;
   ccr_pkg::req_data_type  req_data;
   ccr_pkg::req_user_type  req_user;
   ccr_pkg::rsp_data_type  rsp_data;

   logic [ccr_pkg::CFG_W-1:0]  width_ff, height_ff;
   logic [ccr_pkg::BYTE_W-1:0] background_ff;

   // Configuration registers; a write to an unused index is dropped.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff      <= ccr_pkg::WIDTH_RESET;
         height_ff     <= ccr_pkg::HEIGHT_RESET;
         background_ff <= ccr_pkg::BACKGROUND_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            ccr_pkg::CSR_WIDTH:      width_ff      <= csr_data;
            ccr_pkg::CSR_HEIGHT:     height_ff     <= csr_data;
            ccr_pkg::CSR_BACKGROUND: background_ff <= csr_data[ccr_pkg::BYTE_W-1:0];
            default: ;
         endcase
      end
   end

   assign req_data  = req_tdata;
   assign req_user  = req_tuser;
   assign rsp_tdata = rsp_data;

   ccr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   ccr_datapath #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .FRAC_BITS  (FRAC_BITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_data       (req_data),
      .req_user       (req_user),
      .cfg_width      (width_ff),
      .cfg_height     (height_ff),
      .cfg_background (background_ff),
      .rsp_data       (rsp_data),
      .rsp_status     (rsp_tuser)
   );

endmodule

// ===== design/ccr_checker.sv =====
// Port-level checker of the circle canvas rasterizer and its bind to the top level.
`include "circle_canvas_rasterizer_assert.svh"

module ccr_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic [ccr_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input logic [ccr_pkg::STATUS_W-1:0]    rsp_tuser,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready
);

   ccr_pkg::rsp_data_type rsp_view;

   assign rsp_view = rsp_tdata;

   // A stalled response keeps its contents.
   `CCR_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "Stalled response changed")

   // A failed request carries a zero pixel value.
   `CCR_ASSERT(a_pixel_zero, clock, reset, rsp_tvalid && (rsp_tuser != ccr_pkg::STATUS_OK) |-> (rsp_view.pixel_value == '0), "Pixel value on a failed request")

   // A rejected shape always shows the sticky error flag.
   `CCR_ASSERT(a_reject_sticky, clock, reset, rsp_tvalid && (rsp_tuser == ccr_pkg::STATUS_SHAPE) |-> rsp_view.error_seen, "Rejected shape without error flag")

   // After a request is taken the block is busy and drops ready.
   `CCR_ASSERT(a_one_at_a_time, clock, reset, req_tvalid && req_tready |=> !req_tready, "Request taken while busy")

   // Reset leaves the block idle with no response pending.
   `CCR_ASSERT_NR(a_reset_idle, clock, reset |=> !rsp_tvalid && req_tready, "Block not idle after reset")

endmodule

bind circle_canvas_rasterizer ccr_checker u_ccr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready)
);

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the circle canvas rasterizer: directed table, random requests.
module testbench;
   import ccr_pkg::*;

   localparam int MAX_W       = 256;
   localparam int MAX_H       = 256;
   localparam int FRAC        = 8;
   localparam int ONE         = 1 << FRAC;
   localparam int CYCLE_LIMIT = 2_000_000;
   localparam int TAIL_CYCLES = 20;
   localparam int HOLD_CYCLES = 400;
   localparam int PHASE_ITEMS = 34;
   localparam int STIM_ROWS   = 34;

   // Register index with no register behind it, and a kind byte that is no circle.
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED   = 2'd3;
   localparam logic [BYTE_W-1:0]      KIND_UNKNOWN = 8'h78;

   typedef struct packed {
      logic [MODE_W-1:0]         mode;
      logic [BYTE_W-1:0]         kind;
      logic signed [COORD_W-1:0] cx;
      logic signed [COORD_W-1:0] cy;
      logic signed [COORD_W-1:0] rad;
      logic [BYTE_W-1:0]         paint;
      logic [BYTE_W-1:0]         rrow;
      logic [BYTE_W-1:0]         rcol;
   } raster_req_t;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [BYTE_W-1:0]   pixel;
      logic                err;
   } raster_rsp_t;

   typedef enum logic {ROW_CSR, ROW_REQ} row_kind_e;

   typedef struct packed {
      row_kind_e              kind;
      logic [CSR_INDEX_W-1:0] idx;
      logic [CFG_W-1:0]       val;
      raster_req_t            req;
      logic                   typed;
      raster_rsp_t            want;
   } stim_row_t;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic [REQ_TUSER_W-1:0] req_tuser  = '0;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [STATUS_W-1:0]    rsp_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [CFG_W-1:0]       csr_data   = '0;

   // Shadow copy of the canvas, the registers and the sticky flag.
   logic [BYTE_W-1:0] canvas_copy [MAX_W*MAX_H];
   bit                pixel_written [MAX_W*MAX_H];
   int unsigned       width_reg      = WIDTH_RESET;
   int unsigned       height_reg     = HEIGHT_RESET;
   logic [BYTE_W-1:0] background_reg = BACKGROUND_RESET;
   bit                shape_error    = 1'b0;

   raster_rsp_t pending_results [$];
   int          fail_count  = 0;
   int          tx_idle_pct = 27;
   int          rx_idle_pct = 88;
   int          hold_asked  = 0;
   int          hold_taken  = 0;
   int          hold_left   = 0;

   // Directed requests; the expected response is typed in where it is obvious.
   stim_row_t stim_table [STIM_ROWS] = '{
      // Read outside the 1 by 1 canvas right after reset.
      '{ROW_REQ, '0, '0, '{MODE_READ, 8'h00, 24'h000000, 24'h000000, 24'h000000,
         8'h00, 8'd1, 8'd0}, 1'b1, '{STATUS_RANGE, 8'h00, 1'b0}},
      // Unused mode with every field at all ones.
      '{ROW_REQ, '0, '0, '{MODE_NOP, 8'hFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
         8'hFF, 8'hFF, 8'hFF}, 1'b1, '{STATUS_OK, 8'h00, 1'b0}},
      '{ROW_REQ, '0, '0, '{MODE_CLEAR, 8'h00, 24'h000000, 24'h000000, 24'h000000,
         8'h00, 8'd0, 8'd0}, 1'b1, '{STATUS_OK, 8'h00, 1'b0}},
      '{ROW_REQ, '0, '0, '{MODE_READ, 8'h00, 24'h000000, 24'h000000, 24'h000000,
         8'h00, 8'd0, 8'd0}, 1'b1, '{STATUS_OK, BACKGROUND_RESET, 1'b0}},
      // Rejected shapes: zero radius, unknown kind, most negative radius.
      '{ROW_REQ, '0, '0, '{MODE_DRAW, KIND_FILLED, 24'h000000, 24'h000000, 24'h000000,
         8'h12, 8'd0, 8'd0}, 1'b1, '{STATUS_SHAPE, 8'h00, 1'b1}},
      '{ROW_REQ, '0, '0, '{MODE_DRAW, KIND_UNKNOWN, 24'h000000, 24'h000000, 24'h000100,
         8'h12, 8'd0, 8'd0}, 1'b1, '{STATUS_SHAPE, 8'h00, 1'b1}},
      '{ROW_REQ, '0, '0, '{MODE_DRAW, KIND_OUTLINE, 24'h000000, 24'h000000, 24'h800000,
         8'h12, 8'd0, 8'd0}, 1'b1, '{STATUS_SHAPE, 8'h00, 1'b1}},
      // The flag stays set until the next clear.
      '{ROW_REQ, '0, '0, '{MODE_READ, 8'h00, 24'h000000, 24'h000000, 24'h000000,
         8'h00, 8'd0, 8'd0}, 1'b1, '{STATUS_OK, BACKGROUND_RESET, 1'b1}},
      '{ROW_REQ, '0, '0, '{MODE_CLEAR, 8'h00, 24'h000000, 24'h000000, 24'h000000,
         8'h00, 8'd0, 8'd0}, 1'b1, '{STATUS_OK, 8'h00, 1'b0}},
      // An 8 by 6 canvas; the background write carries a ninth bit that is dropped.
      '{ROW_CSR, CSR_BACKGROUND, 9'h1A5, '0, 1'b0, '0},
      '{ROW_CSR, CSR_WIDTH, 9'd8, '0, 1'b0, '0},
      '{ROW_CSR, CSR_HEIGHT, 9'd6, '0, 1'b0, '0},
      '{ROW_CSR, CSR_UNUSED, 9'h1FF, '0, 1'b0, '0},
      '{ROW_REQ, '0, '0, '{MODE_CLEAR, 8'h00, 24'h000000, 24'h000000, 24'h000000,
         8'h00, 8'd0, 8'd0}, 1'b1, '{STATUS_OK, 8'h00, 1'b0}},
      '{ROW_REQ, '0, '0, '{MODE_READ, 8'h00, 24'h000000, 24'h000000, 24'h000000,
         8'h00, 8'd5, 8'd7}, 1'b1, '{STATUS_OK, 8'hA5, 1'b0}},
      // Filled at (3, 2) radius 2; outline at (4.5, 3) radius 2.5.
      '{ROW_REQ, '0, '0, '{MODE_DRAW, KIND_FILLED, 24'h000300, 24'h000200, 24'h000200,
         8'h11, 8'd0, 8'd0}, 1'b0, '0},
      '{ROW_REQ, '0, '0, '{MODE_DRAW, KIND_OUTLINE, 24'h000480, 24'h000300, 24'h000280,
         8'h22, 8'd0, 8'd0}, 1'b0, '0},
      // Outline below one unit paints every inside pixel; exactly one unit skips the center.
      '{ROW_REQ, '0, '0, '{MODE_DRAW, KIND_OUTLINE, 24'h000100, 24'h000100, 24'h000080,
         8'h00, 8'd0, 8'd0}, 1'b0, '0},
      '{ROW_REQ, '0, '0, '{MODE_DRAW, KIND_OUTLINE, 24'h000600, 24'h000400, 24'h000100,
         8'hFF, 8'd0, 8'd0}, 1'b0, '0},
      // Extreme centers and radii.
      '{ROW_REQ, '0, '0, '{MODE_DRAW, KIND_FILLED, 24'h800000, 24'h800000, 24'h7FFFFF,
         8'h44, 8'd0, 8'd0}, 1'b0, '0},
      '{ROW_REQ, '0, '0, '{MODE_DRAW, KIND_OUTLINE, 24'h000000, 24'h000000, 24'h7FFFFF,
         8'h55, 8'd0, 8'd0}, 1'b0, '0},
      '{ROW_REQ, '0, '0, '{MODE_DRAW, KIND_FILLED, 24'h7FFFFF, 24'h7FFFFF, 24'h000001,
         8'h66, 8'd0, 8'd0}, 1'b0, '0},
      '{ROW_REQ, '0, '0, '{MODE_READ, 8'h00, 24'h000000, 24'h000000, 24'h000000,
         8'h00, 8'd3, 8'd4}, 1'b0, '0},
      '{ROW_REQ, '0, '0, '{MODE_READ, 8'h00, 24'h000000, 24'h000000, 24'h000000,
         8'h00, 8'd6, 8'd0}, 1'b1, '{STATUS_RANGE, 8'h00, 1'b0}},
      // Width zero counts as one, a height above the maximum as the maximum.
      '{ROW_CSR, CSR_WIDTH, 9'd0, '0, 1'b0, '0},
      '{ROW_CSR, CSR_HEIGHT, 9'h1FF, '0, 1'b0, '0},
      '{ROW_REQ, '0, '0, '{MODE_CLEAR, 8'h00, 24'h000000, 24'h000000, 24'h000000,
         8'h00, 8'd0, 8'd0}, 1'b1, '{STATUS_OK, 8'h00, 1'b0}},
      '{ROW_REQ, '0, '0, '{MODE_READ, 8'h00, 24'h000000, 24'h000000, 24'h000000,
         8'h00, 8'd255, 8'd0}, 1'b1, '{STATUS_OK, 8'hA5, 1'b0}},
      '{ROW_REQ, '0, '0, '{MODE_READ, 8'h00, 24'h000000, 24'h000000, 24'h000000,
         8'h00, 8'd0, 8'd1}, 1'b1, '{STATUS_RANGE, 8'h00, 1'b0}},
      // The same the other way round: one row of the full width.
      '{ROW_CSR, CSR_WIDTH, 9'd257, '0, 1'b0, '0},
      '{ROW_CSR, CSR_HEIGHT, 9'd0, '0, 1'b0, '0},
      '{ROW_REQ, '0, '0, '{MODE_CLEAR, 8'h00, 24'h000000, 24'h000000, 24'h000000,
         8'h00, 8'd0, 8'd0}, 1'b1, '{STATUS_OK, 8'h00, 1'b0}},
      '{ROW_REQ, '0, '0, '{MODE_DRAW, KIND_FILLED, 24'h008000, 24'h000000, 24'h000300,
         8'h77, 8'd0, 8'd0}, 1'b0, '0},
      '{ROW_REQ, '0, '0, '{MODE_READ, 8'h00, 24'h000000, 24'h000000, 24'h000000,
         8'h00, 8'd0, 8'd129}, 1'b0, '0}
   };

   circle_canvas_rasterizer #(
      .MAX_WIDTH (MAX_W),
      .MAX_HEIGHT(MAX_H),
      .FRAC_BITS (FRAC)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // Clock with a 10 ns period.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Canvas size in use after clamping the registers.
   function automatic int columns_in_use();
      if (width_reg < 1) return 1;
      if (width_reg > MAX_W) return MAX_W;
      return int'(width_reg);
   endfunction

   function automatic int rows_in_use();
      if (height_reg < 1) return 1;
      if (height_reg > MAX_H) return MAX_H;
      return int'(height_reg);
   endfunction

   // Applies one request to the shadow canvas and returns the response it must give.
   function automatic raster_rsp_t rasterize_request(raster_req_t rq);
      raster_rsp_t res;
      int          w;
      int          h;
      longint      r;
      longint      ctr_x;
      longint      ctr_y;
      longint      dx;
      longint      dy;
      longint      d2;
      longint      r2;
      longint      ri2;
      bit          inner_all;
      res   = '0;
      w     = columns_in_use();
      h     = rows_in_use();
      r     = longint'(signed'(rq.rad));
      ctr_x = longint'(signed'(rq.cx));
      ctr_y = longint'(signed'(rq.cy));
      case (rq.mode)
         MODE_CLEAR: begin
            for (int row = 0; row < h; row++) begin
               for (int col = 0; col < w; col++) begin
                  canvas_copy[row * MAX_W + col]   = background_reg;
                  pixel_written[row * MAX_W + col] = 1'b1;
               end
            end
            shape_error = 1'b0;
         end
         MODE_DRAW: begin
            if (r <= 0 || (rq.kind != KIND_OUTLINE && rq.kind != KIND_FILLED)) begin
               res.status  = STATUS_SHAPE;
               shape_error = 1'b1;
            end else begin
               // Squared distances only; the inner ring vanishes below one unit.
               r2        = r * r;
               inner_all = (r - ONE) < 0;
               ri2       = inner_all ? 0 : (r - ONE) * (r - ONE);
               for (int row = 0; row < h; row++) begin
                  dy = longint'(row) * ONE - ctr_y;
                  for (int col = 0; col < w; col++) begin
                     dx = longint'(col) * ONE - ctr_x;
                     d2 = dx * dx + dy * dy;
                     if (d2 <= r2 && (rq.kind == KIND_FILLED || inner_all || d2 > ri2)) begin
                        canvas_copy[row * MAX_W + col]   = rq.paint;
                        pixel_written[row * MAX_W + col] = 1'b1;
                     end
                  end
               end
            end
         end
         MODE_READ: begin
            if (int'(rq.rrow) >= h || int'(rq.rcol) >= w)
               res.status = STATUS_RANGE;
            else
               res.pixel = canvas_copy[int'(rq.rrow) * MAX_W + int'(rq.rcol)];
         end
         default: ;
      endcase
      res.err = shape_error;
      return res;
   endfunction

   // Mostly clears and well-formed draws and reads on the canvas in use, the rest random noise.
   function automatic raster_req_t random_request();
      raster_req_t rq;
      int          pick;
      int          w;
      int          h;
      int          span;
      w        = columns_in_use();
      h        = rows_in_use();
      span     = ((w > h) ? w : h) * ONE;
      pick     = int'($urandom_range(99));
      rq.mode  = MODE_W'($urandom_range(3));
      rq.kind  = BYTE_W'($urandom);
      rq.cx    = COORD_W'($urandom);
      rq.cy    = COORD_W'($urandom);
      rq.rad   = COORD_W'($urandom);
      rq.paint = BYTE_W'($urandom);
      rq.rrow  = BYTE_W'($urandom);
      rq.rcol  = BYTE_W'($urandom);
      if (pick < 10) begin
         rq.mode = MODE_CLEAR;
      end else if (pick < 55) begin
         rq.mode = MODE_DRAW;
         rq.kind = $urandom_range(1) ? KIND_FILLED : KIND_OUTLINE;
         rq.cx   = COORD_W'(int'($urandom_range((w + 2) * ONE)) - ONE);
         rq.cy   = COORD_W'(int'($urandom_range((h + 2) * ONE)) - ONE);
         rq.rad  = COORD_W'($urandom_range(1, span));
      end else if (pick < 85) begin
         rq.mode = MODE_READ;
         rq.rrow = BYTE_W'($urandom_range(h - 1));
         rq.rcol = BYTE_W'($urandom_range(w - 1));
      end
      // A pixel that was never written must not be read; clear instead.
      if (rq.mode == MODE_READ && int'(rq.rrow) < h && int'(rq.rcol) < w &&
          !pixel_written[int'(rq.rrow) * MAX_W + int'(rq.rcol)])
         rq.mode = MODE_CLEAR;
      return rq;
   endfunction

   // Offers one request, records its expected response once taken, then maybe idles.
   task automatic issue_request(raster_req_t rq, logic typed, raster_rsp_t want);
      req_data_type d;
      req_user_type u;
      raster_rsp_t  pred;
      d.center_x   = rq.cx;
      d.center_y   = rq.cy;
      d.radius     = rq.rad;
      d.paint_byte = rq.paint;
      d.read_row   = rq.rrow;
      d.read_col   = rq.rcol;
      u.mode       = rq.mode;
      u.shape_kind = rq.kind;
      req_tdata  <= d;
      req_tuser  <= u;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pred = rasterize_request(rq);
      pending_results.push_back(typed ? want : pred);
      if ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   // Stops offering requests until every response is back and the block has settled.
   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // Writes one register while the block is idle and mirrors it in the shadow copy.
   task automatic write_register(logic [CSR_INDEX_W-1:0] idx, logic [CFG_W-1:0] val);
      wait_for_results();
      csr_index <= idx;
      csr_data  <= val;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_WIDTH:      width_reg = val;
         CSR_HEIGHT:     height_reg = val;
         CSR_BACKGROUND: background_reg = val[BYTE_W-1:0];
         default: ;
      endcase
      csr_valid <= 1'b0;
   endtask

   // Response side: compare each taken response with the oldest expectation, drive ready.
   always @(posedge clock) begin : response_check
      rsp_data_type got;
      raster_rsp_t  want;
      got = rsp_tdata;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: response with no request waiting: status %0d, pixel %02h",
                     $time, rsp_tuser, got.pixel_value);
            fail_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_tuser !== want.status) begin
               $display("%0t: status mismatch: expected %0d, got %0d",
                        $time, want.status, rsp_tuser);
               fail_count++;
            end
            if (got.pixel_value !== want.pixel) begin
               $display("%0t: pixel mismatch: expected %02h, got %02h",
                        $time, want.pixel, got.pixel_value);
               fail_count++;
            end
            if (got.error_seen !== want.err) begin
               $display("%0t: error flag mismatch: expected %0d, got %0d",
                        $time, want.err, got.error_seen);
               fail_count++;
            end
            if (got.pad !== '0) begin
               $display("%0t: pad mismatch: expected %02h, got %02h", $time, 7'h00, got.pad);
               fail_count++;
            end
         end
      end
      // A long hold-off is counted here; otherwise ready follows the idle ratio.
      if (hold_taken != hold_asked) begin
         hold_taken = hold_asked;
         hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   // Ends a hung run.
   initial begin : watchdog
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("Some tests failed");
      $finish;
   end

   initial begin : stimulus
      raster_req_t rq;
      stim_row_t   row;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed table.
      foreach (stim_table[i]) begin
         row = stim_table[i];
         if (row.kind == ROW_CSR)
            write_register(row.idx, row.val);
         else
            issue_request(row.req, row.typed, row.want);
      end

      // Random phases on small canvases with different idle patterns.
      for (int phase = 0; phase < 3; phase++) begin
         write_register(CSR_WIDTH, CFG_W'($urandom_range(1, 16)));
         write_register(CSR_HEIGHT, CFG_W'($urandom_range(1, 16)));
         write_register(CSR_BACKGROUND, CFG_W'($urandom_range(511)));
         tx_idle_pct = (phase == 0) ? 27 : (phase == 1) ? 88 : 0;
         rx_idle_pct = (phase == 0) ? 88 : (phase == 1) ? 27 : 0;
         if (phase == 2) hold_asked++;
         repeat (PHASE_ITEMS) issue_request(random_request(), 1'b0, '0);
      end

      // Full 256 by 256 canvas: one clear, one circle, a few reads.
      write_register(CSR_WIDTH, 9'd256);
      write_register(CSR_HEIGHT, 9'd300);
      rq      = '0;
      rq.mode = MODE_CLEAR;
      issue_request(rq, 1'b0, '0);
      rq.mode  = MODE_DRAW;
      rq.kind  = $urandom_range(1) ? KIND_FILLED : KIND_OUTLINE;
      rq.cx    = COORD_W'($urandom_range(MAX_W * ONE));
      rq.cy    = COORD_W'($urandom_range(MAX_H * ONE));
      rq.rad   = COORD_W'($urandom_range(ONE, 128 * ONE));
      rq.paint = BYTE_W'($urandom);
      issue_request(rq, 1'b0, '0);
      rq.mode = MODE_READ;
      repeat (8) begin
         rq.rrow = BYTE_W'($urandom);
         rq.rcol = BYTE_W'($urandom);
         issue_request(rq, 1'b0, '0);
      end

      wait_for_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+design
design/ccr_pkg.sv
design/ccr_ctrl.sv
design/ccr_datapath.sv
design/circle_canvas_rasterizer.sv
design/ccr_checker.sv
bench/testbench.sv
